// ===== sv/ct3_pkg.sv =====
// Shared types, constants and the census compare function for the 3x3 census transform.
package ct3_pkg;

    localparam int PIX_W       = 8;
    localparam int CODE_W      = 8;
    localparam int ROWS_W      = 11;
    localparam int COLS_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int MIN_DIM     = 3;

    localparam logic [ROWS_W-1:0] ROWS_RESET = 11'd480;
    localparam logic [COLS_W-1:0] COLS_RESET = 16'd640;

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t REG_IMAGE_ROWS = 1'b0;
    localparam cfg_index_t REG_IMAGE_COLS = 1'b1;

    typedef logic [PIX_W-1:0] pixel_t;

    // Window rows run top to bottom, and within a row the oldest column comes first.
    typedef logic [8:0][PIX_W-1:0] window_t;

    // One pixel word with the two stored pixels of its row and its position flags.
    typedef struct packed {
        pixel_t col_a;
        pixel_t col_b;
        pixel_t px;
        logic   emit;
        logic   last;
    } pix_rec_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
        logic              full;
    } queue_status_t;

    // Bit i is set when the centre is at least neighbor i.
    function automatic logic [CODE_W-1:0] census_code(input window_t w);
        logic [CODE_W-1:0] code;
        code[0] = (w[4] >= w[0]);
        code[1] = (w[4] >= w[1]);
        code[2] = (w[4] >= w[2]);
        code[3] = (w[4] >= w[3]);
        code[4] = (w[4] >= w[5]);
        code[5] = (w[4] >= w[6]);
        code[6] = (w[4] >= w[7]);
        code[7] = (w[4] >= w[8]);
        return code;
    endfunction

endpackage

// ===== sv/ct3_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ct3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/ct3_front.sv =====
// Front end: configuration, frame position counters, column stores and word classification.
module ct3_front
    import ct3_pkg::*;
#(
    parameter int MAX_ROWS = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pixel_t                s_pixel,
    input  queue_status_t         q_status,
    output logic                  q_push,
    output pix_rec_t              q_rec
);

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int RW    = (RCW > ROWS_W) ? RCW : ROWS_W;

    logic [ROWS_W-1:0] image_rows_reg;
    logic [COLS_W-1:0] image_cols_reg;

    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [COLS_W-1:0] col_cnt_reg, col_cnt_next;

    logic              s1_valid_reg;
    pixel_t            s1_px_reg;
    logic [ROW_W-1:0]  s1_addr_reg;
    logic              s1_emit_reg;
    logic              s1_last_reg;

    logic [RW-1:0]     rows_wide;
    logic [RW-1:0]     rows_eff;
    logic [COLS_W-1:0] cols_eff;
    logic              last_row;
    logic              last_col;
    logic              emit;
    logic              accept;
    pixel_t            rd_a;
    pixel_t            rd_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_rows_reg <= ROWS_RESET;
            image_cols_reg <= COLS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_ROWS: image_rows_reg <= cfg_wdata[ROWS_W-1:0];
                REG_IMAGE_COLS: image_cols_reg <= cfg_wdata[COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp both dimensions to at least MIN_DIM, and the rows to what the stores can hold.
    always_comb begin
        rows_wide = RW'(image_rows_reg);
        if (rows_wide < RW'(MIN_DIM)) begin
            rows_eff = RW'(MIN_DIM);
        end else if (rows_wide > RW'(MAX_ROWS)) begin
            rows_eff = RW'(MAX_ROWS);
        end else begin
            rows_eff = rows_wide;
        end
        if (image_cols_reg < COLS_W'(MIN_DIM)) begin
            cols_eff = COLS_W'(MIN_DIM);
        end else begin
            cols_eff = image_cols_reg;
        end
    end

    assign last_row = ((RW + 1)'(row_cnt_reg) + (RW + 1)'(1)) >= (RW + 1)'(rows_eff);
    assign last_col = ((COLS_W + 1)'(col_cnt_reg) + (COLS_W + 1)'(1))
                      >= (COLS_W + 1)'(cols_eff);
    assign emit     = (row_cnt_reg >= ROW_W'(2)) && (col_cnt_reg >= COLS_W'(2));

    // Hold off while the queue could not absorb the word already in flight plus a new one.
    assign s_ready = ((QCNT_W + 1)'(q_status.count) + (QCNT_W + 1)'(s1_valid_reg))
                     < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept  = s_valid && s_ready;

    always_comb begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (accept) begin
            if (last_row) begin
                row_cnt_next = '0;
                col_cnt_next = last_col ? '0 : col_cnt_reg + COLS_W'(1);
            end else begin
                row_cnt_next = row_cnt_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            row_cnt_reg  <= row_cnt_next;
            col_cnt_reg  <= col_cnt_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_px_reg   <= s_pixel;
            s1_addr_reg <= row_cnt_reg;
            s1_emit_reg <= emit;
            s1_last_reg <= last_row && last_col;
        end
    end

    // Store A holds the column two back and store B the column one back.
    ct3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_ROWS)
    ) u_store_a (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (rd_b),
        .rd_en   (accept),
        .rd_addr (row_cnt_reg),
        .rd_data (rd_a)
    );

    ct3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_ROWS)
    ) u_store_b (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_px_reg),
        .rd_en   (accept),
        .rd_addr (row_cnt_reg),
        .rd_data (rd_b)
    );

    assign q_push      = s1_valid_reg;
    assign q_rec.col_a = rd_a;
    assign q_rec.col_b = rd_b;
    assign q_rec.px    = s1_px_reg;
    assign q_rec.emit  = s1_emit_reg;
    assign q_rec.last  = s1_last_reg;

    a_row_wrap : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last_row) |=> (row_cnt_reg == '0))
        else $error("row counter did not wrap at the end of a column");

    a_push_room : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !q_status.full)
        else $error("word accepted without queue room for it");

endmodule

// ===== sv/ct3_queue.sv =====
// Short queue of classified pixel words between the front and back ends.
module ct3_queue
    import ct3_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pix_rec_t      push_rec,
    input  logic          pop,
    output pix_rec_t      pop_rec,
    output queue_status_t status
);

    pix_rec_t          q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_rec;
        end
    end

    assign pop_rec      = q_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

    a_no_overflow : assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!status.full || pop))
        else $error("push into a full queue");

    a_no_underflow : assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !status.empty)
        else $error("pop from an empty queue");

endmodule

// ===== sv/ct3_back.sv =====
// Back end: 3x3 window, census compare and the output register.
module ct3_back
    import ct3_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  queue_status_t     q_status,
    input  pix_rec_t          q_rec,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CODE_W-1:0] m_census,
    output logic              m_frame_last
);

    window_t           win_reg, win_next;
    logic              m_valid_reg, m_valid_next;
    logic [CODE_W-1:0] census_reg;
    logic              last_reg;

    // Words that give no code never wait on the output side.
    assign q_pop = !q_status.empty && (!q_rec.emit || !m_valid_reg || m_ready);

    always_comb begin
        win_next = win_reg;
        if (q_pop) begin
            for (int k = 0; k < 6; k++) begin
                win_next[k] = win_reg[k + 3];
            end
            win_next[6] = q_rec.col_a;
            win_next[7] = q_rec.col_b;
            win_next[8] = q_rec.px;
        end
        if (q_pop && q_rec.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            win_reg     <= win_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_rec.emit) begin
            census_reg <= census_code(win_next);
            last_reg   <= q_rec.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_census     = census_reg;
    assign m_frame_last = last_reg;

    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_rec.emit) |-> (!m_valid_reg || m_ready))
        else $error("code overwritten before it was taken");

endmodule

// ===== sv/census_transform_3x3.sv =====
// An accepted word passes the front-end stage and the queue before its code is registered.
// Throughput: one pixel word per clock, limited by the single port pair of each column store.
// The four-entry queue absorbs a few words while a code waits on the output; a longer
// wait on the output fills it and stalls the input.
// Reset (aresetn low, synchronous) clears counters, window, queue and output valid, and
// loads 480 rows by 640 columns; column store contents are left as they are.
module census_transform_3x3
    import ct3_pkg::*;
#(
    parameter int MAX_ROWS = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration: register 0 is image_rows, register 1 is image_cols.
    input  logic                  cfg_wr_en,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // Pixel input, column by column, top to bottom within a column.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pixel,

    // Census code output for each interior pixel.
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CODE_W-1:0]     m_census,
    output logic                  m_frame_last
);

    // The front end tracks the frame position, reads the two stored columns for the
    // incoming row, rotates the stores, and tags each word with whether it completes
    // a window and whether that window is the last one of the frame.
    queue_status_t q_status;
    logic          q_push;
    logic          q_pop;
    pix_rec_t      q_push_rec;
    pix_rec_t      q_pop_rec;

    ct3_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_rec     (q_push_rec)
    );

    // The queue decouples the store pipeline, which must advance every cycle,
    // from the output side, which may stall.
    ct3_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_rec (q_push_rec),
        .pop      (q_pop),
        .pop_rec  (q_pop_rec),
        .status   (q_status)
    );

    // The back end shifts every word into the window in order and registers a code
    // for each word that completes a window.
    ct3_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_status     (q_status),
        .q_rec        (q_pop_rec),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_census     (m_census),
        .m_frame_last (m_frame_last)
    );

endmodule
